// ----- rtl/unn_pkg.sv -----
// Shared constants for the unit normal pipeline.
package unn_pkg;

    // Coordinate width of the input points and fraction bits of the result.
    localparam int COORD_WIDTH_DEF       = 16;
    localparam int OUT_FRACTION_BITS_DEF = 14;

endpackage

// ----- rtl/unn_front.sv -----
// Front end: input vectors (edge vectors in triangle mode), exact cross product, squared length and remainder seed.
module unn_front #(
    parameter int COORD_WIDTH       = unn_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = unn_pkg::OUT_FRACTION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          operation,
    input  logic signed [COORD_WIDTH-1:0] first_x,
    input  logic signed [COORD_WIDTH-1:0] first_y,
    input  logic signed [COORD_WIDTH-1:0] first_z,
    input  logic signed [COORD_WIDTH-1:0] second_x,
    input  logic signed [COORD_WIDTH-1:0] second_y,
    input  logic signed [COORD_WIDTH-1:0] second_z,
    input  logic signed [COORD_WIDTH-1:0] third_x,
    input  logic signed [COORD_WIDTH-1:0] third_y,
    input  logic signed [COORD_WIDTH-1:0] third_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [4*COORD_WIDTH+9:0]      sum_out,
    output logic [4*COORD_WIDTH+2*OUT_FRACTION_BITS+11:0] rem_out [3],
    output logic                          neg_out [3],
    output logic                          degen_out
);
    localparam int DW  = COORD_WIDTH + 1;
    localparam int PRW = 2 * DW;
    localparam int CRW = PRW + 1;
    localparam int MW  = PRW;
    localparam int SQW = 2 * MW;
    localparam int SW  = 4 * COORD_WIDTH + 10;
    localparam int WW  = SW + 2 * OUT_FRACTION_BITS + 2;

    logic ready1, ready2, ready3, ready4, ready5;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    logic signed [DW-1:0]  u_reg [3];
    logic signed [DW-1:0]  w_reg [3];
    logic signed [DW-1:0]  u_next [3];
    logic signed [DW-1:0]  w_next [3];
    logic signed [PRW-1:0] pa_reg [3];
    logic signed [PRW-1:0] pb_reg [3];
    logic [MW-1:0]         mag_reg [3];
    logic [MW-1:0]         mag_next [3];
    logic                  neg3_reg [3];
    logic                  neg3_next [3];
    logic [SQW-1:0]        sq_reg [3];
    logic                  neg4_reg [3];
    logic [SW-1:0]         sum_reg;
    logic [WW-1:0]         rem_reg [3];
    logic                  neg5_reg [3];

    logic signed [DW-1:0] p1 [3];
    logic signed [DW-1:0] p2 [3];
    logic signed [DW-1:0] p3 [3];
    logic signed [CRW-1:0] cross_c [3];

    assign ready5   = !v5_reg || out_ready;
    assign ready4   = !v4_reg || ready5;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_comb begin
        p1[0] = DW'(first_x);  p1[1] = DW'(first_y);  p1[2] = DW'(first_z);
        p2[0] = DW'(second_x); p2[1] = DW'(second_y); p2[2] = DW'(second_z);
        p3[0] = DW'(third_x);  p3[1] = DW'(third_y);  p3[2] = DW'(third_z);
        for (int i = 0; i < 3; i++) begin
            if (operation) begin
                u_next[i] = p3[i] - p2[i];
                w_next[i] = p1[i] - p2[i];
            end else begin
                u_next[i] = p1[i];
                w_next[i] = p2[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cross_c[i]   = CRW'(pa_reg[i]) - CRW'(pb_reg[i]);
            neg3_next[i] = cross_c[i][CRW-1];
            mag_next[i]  = neg3_next[i] ? MW'(-cross_c[i]) : MW'(cross_c[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg <= in_valid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
            if (ready5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            u_reg <= u_next;
            w_reg <= w_next;
        end
        if (ready2) begin
            pa_reg[0] <= u_reg[1] * w_reg[2];
            pb_reg[0] <= u_reg[2] * w_reg[1];
            pa_reg[1] <= u_reg[2] * w_reg[0];
            pb_reg[1] <= u_reg[0] * w_reg[2];
            pa_reg[2] <= u_reg[0] * w_reg[1];
            pb_reg[2] <= u_reg[1] * w_reg[0];
        end
        if (ready3) begin
            mag_reg  <= mag_next;
            neg3_reg <= neg3_next;
        end
        if (ready4) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            neg4_reg <= neg3_reg;
        end
        if (ready5) begin
            sum_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= WW'(sq_reg[i]) << (2 * OUT_FRACTION_BITS);
            end
            neg5_reg <= neg4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign sum_out   = sum_reg;
    assign rem_out   = rem_reg;
    assign neg_out   = neg5_reg;
    assign degen_out = (sum_reg == '0);

endmodule

// ----- rtl/unn_cell.sv -----
// One result bit of the scaled components: trial subtract against the remainder.
module unn_cell #(
    parameter int COORD_WIDTH       = unn_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = unn_pkg::OUT_FRACTION_BITS_DEF,
    parameter int BIT               = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [4*COORD_WIDTH+9:0]           sum_in,
    input  logic [4*COORD_WIDTH+2*OUT_FRACTION_BITS+11:0] rem_in [3],
    input  logic [4*COORD_WIDTH+2*OUT_FRACTION_BITS+11:0] acc_in [3],
    input  logic [OUT_FRACTION_BITS:0]         quot_in [3],
    input  logic                               neg_in [3],
    input  logic                               degen_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [4*COORD_WIDTH+9:0]           sum_out,
    output logic [4*COORD_WIDTH+2*OUT_FRACTION_BITS+11:0] rem_out [3],
    output logic [4*COORD_WIDTH+2*OUT_FRACTION_BITS+11:0] acc_out [3],
    output logic [OUT_FRACTION_BITS:0]         quot_out [3],
    output logic                               neg_out [3],
    output logic                               degen_out
);
    localparam int SW = 4 * COORD_WIDTH + 10;
    localparam int WW = SW + 2 * OUT_FRACTION_BITS + 2;
    localparam int QW = OUT_FRACTION_BITS + 1;

    logic              valid_reg;
    logic [SW-1:0]     sum_reg;
    logic [WW-1:0]     rem_reg [3];
    logic [WW-1:0]     rem_next [3];
    logic [WW-1:0]     acc_reg [3];
    logic [WW-1:0]     acc_next [3];
    logic [QW-1:0]     quot_reg [3];
    logic [QW-1:0]     quot_next [3];
    logic              neg_reg [3];
    logic              degen_reg;
    logic [WW-1:0]     delta [3];
    logic [WW-1:0]     sum_wide;

    // acc holds q*s, so (q + 2^b)^2*s - q^2*s = acc*2^(b+1) + s*2^(2b).
    always_comb begin
        sum_wide = WW'(sum_in);
        for (int i = 0; i < 3; i++) begin
            delta[i]     = (acc_in[i] << (BIT + 1)) + (sum_wide << (2 * BIT));
            rem_next[i]  = rem_in[i];
            acc_next[i]  = acc_in[i];
            quot_next[i] = quot_in[i];
            if (delta[i] <= rem_in[i]) begin
                rem_next[i]       = rem_in[i] - delta[i];
                acc_next[i]       = acc_in[i] + (sum_wide << BIT);
                quot_next[i][BIT] = 1'b1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            sum_reg   <= sum_in;
            rem_reg   <= rem_next;
            acc_reg   <= acc_next;
            quot_reg  <= quot_next;
            neg_reg   <= neg_in;
            degen_reg <= degen_in;
        end
    end

    assign out_valid = valid_reg;
    assign sum_out   = sum_reg;
    assign rem_out   = rem_reg;
    assign acc_out   = acc_reg;
    assign quot_out  = quot_reg;
    assign neg_out   = neg_reg;
    assign degen_out = degen_reg;

endmodule

// ----- rtl/unit_normal_unit.sv -----
// Unit normal pipeline: cross product, then a row of cells forming the scaled components.
// The path has five front stages, one cell per result bit, and the output register.
// Throughput is one request per cycle unless m_ready stalls the output; every stage is pipelined and bubbles collapse.
// Reset (aresetn low, synchronous) clears only the stage valid flags; data is not reset.
module unit_normal_unit #(
    parameter int COORD_WIDTH       = unn_pkg::COORD_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = unn_pkg::OUT_FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic signed [COORD_WIDTH-1:0]       s_first_x,
    input  logic signed [COORD_WIDTH-1:0]       s_first_y,
    input  logic signed [COORD_WIDTH-1:0]       s_first_z,
    input  logic signed [COORD_WIDTH-1:0]       s_second_x,
    input  logic signed [COORD_WIDTH-1:0]       s_second_y,
    input  logic signed [COORD_WIDTH-1:0]       s_second_z,
    input  logic signed [COORD_WIDTH-1:0]       s_third_x,
    input  logic signed [COORD_WIDTH-1:0]       s_third_y,
    input  logic signed [COORD_WIDTH-1:0]       s_third_z,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [OUT_FRACTION_BITS+1:0] m_normal_x,
    output logic signed [OUT_FRACTION_BITS+1:0] m_normal_y,
    output logic signed [OUT_FRACTION_BITS+1:0] m_normal_z,
    output logic                                m_degenerate
);
    localparam int SW     = 4 * COORD_WIDTH + 10;
    localparam int WW     = SW + 2 * OUT_FRACTION_BITS + 2;
    localparam int QW     = OUT_FRACTION_BITS + 1;
    localparam int OW     = OUT_FRACTION_BITS + 2;
    localparam int NCELLS = OUT_FRACTION_BITS + 1;

    logic          valid_w [NCELLS+1];
    logic          ready_w [NCELLS+1];
    logic [SW-1:0] sum_w   [NCELLS+1];
    logic [WW-1:0] rem_w   [NCELLS+1][3];
    logic [WW-1:0] acc_w   [NCELLS+1][3];
    logic [QW-1:0] quot_w  [NCELLS+1][3];
    logic          neg_w   [NCELLS+1][3];
    logic          degen_w [NCELLS+1];

    logic                 out_valid_reg;
    logic                 out_ready;
    logic signed [OW-1:0] normal_reg [3];
    logic signed [OW-1:0] normal_next [3];
    logic                 degen_reg;

    unn_front #(
        .COORD_WIDTH      (COORD_WIDTH),
        .OUT_FRACTION_BITS(OUT_FRACTION_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .operation(s_operation),
        .first_x  (s_first_x),
        .first_y  (s_first_y),
        .first_z  (s_first_z),
        .second_x (s_second_x),
        .second_y (s_second_y),
        .second_z (s_second_z),
        .third_x  (s_third_x),
        .third_y  (s_third_y),
        .third_z  (s_third_z),
        .out_valid(valid_w[0]),
        .out_ready(ready_w[0]),
        .sum_out  (sum_w[0]),
        .rem_out  (rem_w[0]),
        .neg_out  (neg_w[0]),
        .degen_out(degen_w[0])
    );

    assign acc_w[0][0]  = '0;
    assign acc_w[0][1]  = '0;
    assign acc_w[0][2]  = '0;
    assign quot_w[0][0] = '0;
    assign quot_w[0][1] = '0;
    assign quot_w[0][2] = '0;

    // Cells run from the top result bit down to bit zero.
    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        unn_cell #(
            .COORD_WIDTH      (COORD_WIDTH),
            .OUT_FRACTION_BITS(OUT_FRACTION_BITS),
            .BIT              (OUT_FRACTION_BITS - k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (valid_w[k]),
            .in_ready (ready_w[k]),
            .sum_in   (sum_w[k]),
            .rem_in   (rem_w[k]),
            .acc_in   (acc_w[k]),
            .quot_in  (quot_w[k]),
            .neg_in   (neg_w[k]),
            .degen_in (degen_w[k]),
            .out_valid(valid_w[k+1]),
            .out_ready(ready_w[k+1]),
            .sum_out  (sum_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .acc_out  (acc_w[k+1]),
            .quot_out (quot_w[k+1]),
            .neg_out  (neg_w[k+1]),
            .degen_out(degen_w[k+1])
        );
    end

    assign out_ready        = !out_valid_reg || m_ready;
    assign ready_w[NCELLS]  = out_ready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (degen_w[NCELLS]) begin
                normal_next[i] = '0;
            end else if (neg_w[NCELLS][i]) begin
                normal_next[i] = -$signed(OW'(quot_w[NCELLS][i]));
            end else begin
                normal_next[i] = $signed(OW'(quot_w[NCELLS][i]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= valid_w[NCELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            normal_reg <= normal_next;
            degen_reg  <= degen_w[NCELLS];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_normal_x   = normal_reg[0];
    assign m_normal_y   = normal_reg[1];
    assign m_normal_z   = normal_reg[2];
    assign m_degenerate = degen_reg;

    localparam logic signed [OW-1:0] ONE_Q = OW'(1) <<< OUT_FRACTION_BITS;

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("degenerate result with nonzero components");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x <= ONE_Q && m_normal_x >= -ONE_Q
                 && m_normal_y <= ONE_Q && m_normal_y >= -ONE_Q
                 && m_normal_z <= ONE_Q && m_normal_z >= -ONE_Q)
        else $error("component beyond unit length");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output register is empty");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ----- tb/sv/unit_normal_unit_tb.sv -----
// Testbench for the unit normal pipeline: directed, random and backpressure tests.
`timescale 1ns / 1ps

module unit_normal_unit_tb;

    localparam int CW = unn_pkg::COORD_WIDTH_DEF;
    localparam int FB = unn_pkg::OUT_FRACTION_BITS_DEF;
    localparam int OW = FB + 2;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES = FB + 20;

    localparam bit OP_CROSS    = 1'b0;
    localparam bit OP_TRIANGLE = 1'b1;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   operation;
        coord_t ax, ay, az;
        coord_t bx, by, bz;
        coord_t cx, cy, cz;
    } triangle_t;

    typedef struct packed {
        logic signed [OW-1:0] nx, ny, nz;
        logic                 degenerate;
    } normal_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OW-1:0] m_normal_x, m_normal_y, m_normal_z;
    logic m_degenerate;
    triangle_t tri_drv = '0;

    normal_t expected_normals[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    unit_normal_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_operation(tri_drv.operation),
        .s_first_x(tri_drv.ax), .s_first_y(tri_drv.ay), .s_first_z(tri_drv.az),
        .s_second_x(tri_drv.bx), .s_second_y(tri_drv.by), .s_second_z(tri_drv.bz),
        .s_third_x(tri_drv.cx), .s_third_y(tri_drv.cy), .s_third_z(tri_drv.cz),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z),
        .m_degenerate(m_degenerate)
    );

    // Exact unit normal: largest q with q^2 * |c|^2 <= c_i^2 * 2^(2F), sign of c_i.
    function automatic normal_t unit_normal(triangle_t t);
        logic signed [CW+1:0] u[3], v[3];
        logic signed [2*CW+5:0] c[3];
        logic [127:0] m[3], len2, target, lhs, cand;
        logic [FB:0] q;
        normal_t n;
        if (t.operation == OP_TRIANGLE) begin
            u[0] = t.cx - t.bx; u[1] = t.cy - t.by; u[2] = t.cz - t.bz;
            v[0] = t.ax - t.bx; v[1] = t.ay - t.by; v[2] = t.az - t.bz;
        end else begin
            u[0] = t.ax; u[1] = t.ay; u[2] = t.az;
            v[0] = t.bx; v[1] = t.by; v[2] = t.bz;
        end
        c[0] = u[1] * v[2] - u[2] * v[1];
        c[1] = u[2] * v[0] - u[0] * v[2];
        c[2] = u[0] * v[1] - u[1] * v[0];
        len2 = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? -c[i] : c[i];
            len2 = len2 + m[i] * m[i];
        end
        n = '0;
        if (len2 == 0) begin
            n.degenerate = 1'b1;
            return n;
        end
        for (int i = 0; i < 3; i++) begin
            target = (m[i] * m[i]) << (2 * FB);
            q = '0;
            for (int b = FB; b >= 0; b--) begin
                cand = 128'(q) | (128'(1) << b);
                lhs = cand * cand * len2;
                if (lhs <= target) q = cand[FB:0];
            end
            if (i == 0) n.nx = (c[i] < 0) ? -OW'(q) : OW'(q);
            if (i == 1) n.ny = (c[i] < 0) ? -OW'(q) : OW'(q);
            if (i == 2) n.nz = (c[i] < 0) ? -OW'(q) : OW'(q);
        end
        return n;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge aclk) begin
        normal_t exp_n;
        if (aresetn && m_valid && m_ready) begin
            if (expected_normals.size() == 0) begin
                $error("unexpected result");
                error_count++;
            end else begin
                exp_n = expected_normals.pop_front();
                if (m_normal_x !== exp_n.nx) begin
                    $error("normal_x expected %0d got %0d", exp_n.nx, m_normal_x);
                    error_count++;
                end
                if (m_normal_y !== exp_n.ny) begin
                    $error("normal_y expected %0d got %0d", exp_n.ny, m_normal_y);
                    error_count++;
                end
                if (m_normal_z !== exp_n.nz) begin
                    $error("normal_z expected %0d got %0d", exp_n.nz, m_normal_z);
                    error_count++;
                end
                if (m_degenerate !== exp_n.degenerate) begin
                    $error("degenerate expected %0d got %0d", exp_n.degenerate,
                           m_degenerate);
                    error_count++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    // Each cycle the sender idles with the set probability before offering the request.
    task automatic send_triangle(triangle_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        tri_drv <= t;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_normals.push_back(unit_normal(t));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_normals.size() != 0) @(negedge aclk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            1, 2: return coord_t'($signed($urandom_range(8)) - 4);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic triangle_t rand_triangle();
        triangle_t t;
        int k;
        t.operation = 1'($urandom_range(1));
        t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
        t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
        t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
        // Now and then make the vectors parallel so the length is zero, unless the coordinates wrap.
        if ($urandom_range(9) == 0) begin
            k = $signed($urandom_range(6)) - 3;
            t.ax = coord_t'($signed($urandom_range(200)) - 100);
            t.ay = coord_t'($signed($urandom_range(200)) - 100);
            t.az = coord_t'($signed($urandom_range(200)) - 100);
            if (t.operation == OP_TRIANGLE) begin
                t.cx = coord_t'(t.bx + k * (t.ax - t.bx));
                t.cy = coord_t'(t.by + k * (t.ay - t.by));
                t.cz = coord_t'(t.bz + k * (t.az - t.bz));
            end else begin
                t.bx = coord_t'(k * t.ax);
                t.by = coord_t'(k * t.ay);
                t.bz = coord_t'(k * t.az);
            end
        end
        return t;
    endfunction

    function automatic triangle_t make_tri(logic op, coord_t ax, coord_t ay, coord_t az,
                                           coord_t bx, coord_t by, coord_t bz,
                                           coord_t cx, coord_t cy, coord_t cz);
        triangle_t t;
        t.operation = op;
        t.ax = ax; t.ay = ay; t.az = az;
        t.bx = bx; t.by = by; t.bz = bz;
        t.cx = cx; t.cy = cy; t.cz = cz;
        return t;
    endfunction

    task automatic test_directed();
        coord_t mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        // Zero vectors are degenerate.
        send_triangle(make_tri(OP_CROSS, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_triangle(make_tri(OP_TRIANGLE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // Axis vectors give a component of exactly plus or minus one.
        send_triangle(make_tri(OP_CROSS, 256, 0, 0, 0, 256, 0, mx, mn, mx));
        send_triangle(make_tri(OP_CROSS, 0, 1, 0, 1, 0, 0, 0, 0, 0));
        send_triangle(make_tri(OP_CROSS, 0, 0, 1, 1, 0, 0, -1, -1, -1));
        send_triangle(make_tri(OP_TRIANGLE, 0, 1, 0, 0, 0, 0, 1, 0, 0));
        // Coincident and collinear points.
        send_triangle(make_tri(OP_TRIANGLE, mx, mn, 5, mx, mn, 5, 0, 0, 0));
        send_triangle(make_tri(OP_TRIANGLE, 1, 2, 3, 0, 0, 0, 2, 4, 6));
        send_triangle(make_tri(OP_CROSS, mx, mx, mx, mn, mn, mn, 0, 0, 0));
        send_triangle(make_tri(OP_CROSS, mn, mn, mn, mn, mn, mn, mx, mx, mx));
        // Extremes of the coordinate range, then small vectors.
        send_triangle(make_tri(OP_CROSS, mx, 0, mn, mn, mx, 0, 0, 0, 0));
        send_triangle(make_tri(OP_CROSS, mn, mx, mn, mx, mn, mn, -1, -1, -1));
        send_triangle(make_tri(OP_TRIANGLE, mx, mn, mn, mn, mx, mx, mx, mx, mn));
        send_triangle(make_tri(OP_TRIANGLE, mn, mn, mx, mx, mx, mn, mn, mx, mx));
        send_triangle(make_tri(OP_TRIANGLE, mx, mx, mx, mn, mn, mn, mx, mn, mx));
        send_triangle(make_tri(OP_TRIANGLE, -1, -1, -1, 0, 0, 0, 1, -1, 1));
        send_triangle(make_tri(OP_CROSS, 1, 1, 1, 1, -1, 0, 0, 0, 0));
        send_triangle(make_tri(OP_CROSS, -1, -1, 0, 1, -1, 0, 0, 0, 0));
        send_triangle(make_tri(OP_CROSS, 3, 4, 0, -4, 3, 0, 7, 7, 7));
    endtask

    task automatic test_random(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) send_triangle(rand_triangle());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 300;
        repeat (100) send_triangle(rand_triangle());
        // Sender pauses until the pipeline is empty, then sends a short burst.
        wait_drained();
        @(negedge aclk);
        repeat (20) send_triangle(rand_triangle());
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(500, 25, 53);
        test_random(500, 53, 25);
        test_random(500, 0, 0);
        test_backpressure();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && expected_normals.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/unn_pkg.sv
rtl/unn_front.sv
rtl/unn_cell.sv
rtl/unit_normal_unit.sv
tb/sv/unit_normal_unit_tb.sv
